### sv/uart_baud_divisor_calculator_core_assert.svh
// assertion macros shared by the baud divisor calculator rtl
`ifndef UART_BAUD_DIVISOR_CALCULATOR_CORE_ASSERT_SVH
`define UART_BAUD_DIVISOR_CALCULATOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked outside reset
`define UBD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// next-cycle implication, checked outside reset
`define UBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`else

`define UBD_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define UBD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### sv/ubd_pkg.sv
// types and constants for the baud divisor calculator
package ubd_pkg;

	localparam int CLOCK_BITS     = 32;
	localparam int DIVISOR_BITS   = 16;
	localparam int PRESCALER_BITS = 8;
	localparam int BAUD_W         = 24;
	// running clock after the divide by 16
	localparam int CLK_W          = CLOCK_BITS - 4;
	// rounded quotient may reach 2^CLK_W
	localparam int QUOT_W         = CLK_W + 1;
	// prescaler before range check: (quot >> DIVISOR_BITS) + 1
	localparam int PSR_W          = QUOT_W - DIVISOR_BITS + 1;
	localparam int CNT_W          = $clog2(CLK_W);
	localparam logic [CLOCK_BITS-1:0] CLOCK_HZ_RESET = CLOCK_BITS'(18432000);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CLK_GO,
		S_CLK_WAIT,
		S_BAUD_GO,
		S_BAUD_WAIT,
		S_CHECK,
		S_DONE
	} ubd_state_t;

	typedef struct packed {
		logic load;
		logic div_start;
		logic div_sel_baud;
		logic save_clk;
		logic save_quot;
		logic set_psr;
		logic load_out;
	} ubd_cmd_t;

	typedef struct packed {
		logic baud_zero;
		logic div_done;
		logic quot_big;
	} ubd_status_t;

endpackage

### sv/ubd_div.sv
// iterative restoring divider, one quotient bit per cycle
module ubd_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [ubd_pkg::CLK_W-1:0]  dividend,
	input  logic [ubd_pkg::BAUD_W-1:0] denom,
	output logic                      done,
	output logic [ubd_pkg::CLK_W-1:0]  quotient,
	output logic [ubd_pkg::BAUD_W-1:0] remainder
);
	import ubd_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CLK_W-1:0]  quo_q;
	logic [BAUD_W-1:0] rem_q;
	logic [BAUD_W-1:0] den_q;
	logic [BAUD_W:0]   trial;

	// trial subtract of the shifted partial remainder
	assign trial = {rem_q, quo_q[CLK_W-1]} - {1'b0, den_q};

	// control of the iteration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(CLK_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// partial remainder and quotient shift
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= denom;
		end else if (busy_q) begin
			quo_q <= {quo_q[CLK_W-2:0], ~trial[BAUD_W]};
			if (!trial[BAUD_W]) begin
				rem_q <= trial[BAUD_W-1:0];
			end else begin
				rem_q <= {rem_q[BAUD_W-2:0], quo_q[CLK_W-1]};
			end
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

### sv/ubd_dp.sv
// datapath: clock register, pass registers, divider and result register
module ubd_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [ubd_pkg::CLOCK_BITS-1:0]  cfg_wr_data,
	input  logic [ubd_pkg::BAUD_W-1:0]      baud_rate,
	input  ubd_pkg::ubd_cmd_t               cmd,
	output ubd_pkg::ubd_status_t            status,
	output logic [ubd_pkg::PRESCALER_BITS-1:0] prescaler,
	output logic [ubd_pkg::DIVISOR_BITS-1:0]   divisor,
	output logic                            ok
);
	import ubd_pkg::*;

	logic [CLOCK_BITS-1:0]     clock_hz_q;
	logic [BAUD_W-1:0]         baud_q;
	logic [CLK_W-1:0]          run_clk_q;
	logic [PSR_W-1:0]          psr_q;
	logic [QUOT_W-1:0]         quot_q;
	logic [PRESCALER_BITS-1:0] prescaler_q;
	logic [DIVISOR_BITS-1:0]   divisor_q;
	logic                      ok_q;

	logic [BAUD_W-1:0]         denom;
	logic                      div_done;
	logic [CLK_W-1:0]          div_quo;
	logic [BAUD_W-1:0]         div_rem;
	logic                      round_up;
	logic                      res_ok;

	// reference clock register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_hz_q <= CLOCK_HZ_RESET;
		end else if (cfg_wr_en) begin
			clock_hz_q <= cfg_wr_data;
		end
	end

	// shared divider: running clock by prescaler, then by baud
	assign denom = cmd.div_sel_baud ? baud_q : BAUD_W'(psr_q);

	ubd_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (run_clk_q),
		.denom     (denom),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// round up only when twice the remainder exceeds the baud
	assign round_up = {div_rem, 1'b0} > {1'b0, baud_q};

	// pass registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			baud_q    <= baud_rate;
			run_clk_q <= clock_hz_q[CLOCK_BITS-1:4];
			psr_q     <= PSR_W'(1);
		end else begin
			if (cmd.save_clk) begin
				run_clk_q <= div_quo;
			end
			if (cmd.set_psr) begin
				psr_q <= PSR_W'(quot_q[QUOT_W-1:DIVISOR_BITS]) + PSR_W'(1);
			end
		end
		if (cmd.save_quot) begin
			quot_q <= {1'b0, div_quo} + QUOT_W'(round_up);
		end
	end

	// result register
	assign res_ok = (baud_q != '0) && (psr_q[PSR_W-1:PRESCALER_BITS] == '0);

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			ok_q        <= res_ok;
			prescaler_q <= res_ok ? psr_q[PRESCALER_BITS-1:0] : '0;
			divisor_q   <= res_ok ? quot_q[DIVISOR_BITS-1:0] : '0;
		end
	end

	assign status.baud_zero = (baud_q == '0);
	assign status.div_done  = div_done;
	assign status.quot_big  = (quot_q[QUOT_W-1:DIVISOR_BITS] != '0);

	assign prescaler = prescaler_q;
	assign divisor   = divisor_q;
	assign ok        = ok_q;

endmodule

### sv/ubd_ctrl.sv
// controller: sequences the passes and the result handshake
module ubd_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  ubd_pkg::ubd_status_t status,
	output ubd_pkg::ubd_cmd_t    cmd
);
	import ubd_pkg::*;

	ubd_state_t state_q, state_d;
	logic       out_valid_q;

	// state register and result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CLK_GO;
				end
			end
			S_CLK_GO: begin
				if (status.baud_zero) begin
					state_d = S_DONE;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = S_CLK_WAIT;
				end
			end
			S_CLK_WAIT: begin
				if (status.div_done) begin
					cmd.save_clk = 1'b1;
					state_d      = S_BAUD_GO;
				end
			end
			S_BAUD_GO: begin
				cmd.div_start    = 1'b1;
				cmd.div_sel_baud = 1'b1;
				state_d          = S_BAUD_WAIT;
			end
			S_BAUD_WAIT: begin
				cmd.div_sel_baud = 1'b1;
				if (status.div_done) begin
					cmd.save_quot = 1'b1;
					state_d       = S_CHECK;
				end
			end
			S_CHECK: begin
				if (status.quot_big) begin
					cmd.set_psr = 1'b1;
					state_d     = S_CLK_GO;
				end else begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

endmodule

### sv/uart_baud_divisor_calculator_core.sv
// top level of the uart baud divisor calculator
//
//   channel   signals                          direction
//   in        in_valid/in_ready, baud_rate      into block
//   out       out_valid/out_ready, prescaler,   out of block
//             divisor, ok
//   cfg       cfg_wr_en, cfg_wr_data            into block, no wait
//
// one item at a time; a pass runs S_CLK_GO, S_CLK_WAIT, S_BAUD_GO, S_BAUD_WAIT, S_CHECK:
// two runs of the one shared bit-serial divider (a start state plus a wait state each)
// and a check; an item usually takes one or two passes, at most three; a zero baud goes from S_CLK_GO to S_DONE.
// the reference clock register resets to 18432000; no clearing pass is needed.
// a finished result waits in the output register; the next item is taken
// while it waits, and only the following result stalls on out_ready.
module uart_baud_divisor_calculator_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [ubd_pkg::CLOCK_BITS-1:0]     cfg_wr_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [ubd_pkg::BAUD_W-1:0]         baud_rate,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [ubd_pkg::PRESCALER_BITS-1:0] prescaler,
	output logic [ubd_pkg::DIVISOR_BITS-1:0]   divisor,
	output logic                               ok
);
	import ubd_pkg::*;

	`include "uart_baud_divisor_calculator_core_assert.svh"

	ubd_cmd_t    cmd;
	ubd_status_t status;

	// sequencer
	ubd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// arithmetic and storage
	ubd_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.baud_rate   (baud_rate),
		.cmd         (cmd),
		.status      (status),
		.prescaler   (prescaler),
		.divisor     (divisor),
		.ok          (ok)
	);

	// an accepted transfer keeps the input closed while it is worked on
	`UBD_ASSERT_NEXT(a_busy_after_take, clk, arst_n, in_valid && in_ready, !in_ready)
	// a valid result always carries a nonzero prescaler
	`UBD_ASSERT_IMPL(a_ok_psr, clk, arst_n, out_valid && ok, prescaler != '0)
	// a flagged result is all zero
	`UBD_ASSERT_IMPL(a_bad_zero, clk, arst_n, out_valid && !ok, (prescaler == '0) && (divisor == '0))
	// the divider is never started while a result load or an input load is pending
	`UBD_ASSERT_IMPL(a_cmd_excl, clk, arst_n, cmd.div_start, !cmd.load_out && !cmd.load)

endmodule
